### design/kcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcq_pkg
// Shared types and constants for the k-means colour quantizer.
// ----------------------------------------------------------------------------
package kcq_pkg;

  localparam int PIX_W  = 8;   // colour component of a pixel
  localparam int FRAC_W = 8;   // fraction bits of a centroid component
  localparam int COMP_W = 16;  // unsigned 8.8 centroid component
  localparam int IDX_W  = 4;   // cluster index and label
  localparam int CFG_W  = 5;   // clusters_in_use register
  localparam int CFG_RESET = 8;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_END      = 2'd2,
    CMD_LOOKUP   = 2'd3
  } cmd_e;

  // One command as it travels through the queue
  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

### design/kcq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kcq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/kcq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcq_div
// Restoring divider, one quotient bit a cycle: (sum << 8) / count.
// Keeps the low 16 quotient bits.
// ----------------------------------------------------------------------------
module kcq_div #(
  parameter int SumW = 30,
  parameter int DenW = 23
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SumW-1:0]           sum_i,
  input  logic [DenW-1:0]           den_i,
  output logic                      done_o,
  output logic [kcq_pkg::COMP_W-1:0] quo_o
);
  import kcq_pkg::*;

  localparam int DvdW = SumW + FRAC_W;
  localparam int CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [COMP_W-1:0] quo_q, quo_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DenW:0]     rs;
  logic [DenW:0]     diff;

  // One shift-subtract step
  always_comb begin
    rs     = {rem_q, dvd_q[DvdW-1]};
    diff   = rs - {1'b0, den_q};
    dvd_d  = dvd_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = {sum_i, {FRAC_W{1'b0}}};
      den_d = den_i;
      rem_d = '0;
      cnt_d = CntW'(DvdW);
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      if (rs >= {1'b0, den_q}) begin
        rem_d = diff[DenW-1:0];
        quo_d = {quo_q[COMP_W-2:0], 1'b1};
      end else begin
        rem_d = rs[DenW-1:0];
        quo_d = {quo_q[COMP_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### design/kcq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcq_front
// Input side: accepts command transactions and queues them for the back end.
// ----------------------------------------------------------------------------
module kcq_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  output kcq_pkg::qhead_t        head_o,
  input  logic                   pop_i
);
  import kcq_pkg::*;

  item_t      slot_q [2];
  item_t      in_item;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  // Unpack the transaction
  always_comb begin
    in_item.cmd   = cmd_e'(s_axis_tuser);
    in_item.idx   = s_axis_tdata[3:0];
    in_item.red   = s_axis_tdata[11:4];
    in_item.green = s_axis_tdata[19:12];
    in_item.blue  = s_axis_tdata[27:20];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;

  // Two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_item;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = slot_q[rd_q];

endmodule

### design/kcq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcq_back
// Command execution: centroid store, nearest-centroid search, accumulators
// and the end-of-pass update. Holds the result register.
// ----------------------------------------------------------------------------
module kcq_back #(
  parameter int MaxClusters    = 16,
  parameter int PixelCountBits = 22
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [kcq_pkg::CFG_W-1:0]  k_cfg_i,
  input  kcq_pkg::qhead_t            head_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata
);
  import kcq_pkg::*;

  localparam int CW   = $clog2(MaxClusters);
  localparam int SW   = PixelCountBits + PIX_W;
  localparam int NW   = PixelCountBits + 1;
  localparam int AWD  = 3 * SW + NW;
  localparam int CEW  = 3 * COMP_W;
  localparam int SQW  = 2 * COMP_W;
  localparam int DW   = SQW + 2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_LKRD  = 10'b00_0000_0010,
    S_SCAN  = 10'b00_0000_0100,
    S_DRAIN = 10'b00_0000_1000,
    S_ARD   = 10'b00_0001_0000,
    S_AUPD  = 10'b00_0010_0000,
    S_ERD   = 10'b00_0100_0000,
    S_EWAIT = 10'b00_1000_0000,
    S_EDIV  = 10'b01_0000_0000,
    S_EWR   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q, item_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] k_last;
  logic          ovf_q, ovf_d;

  // RAM ports
  logic            cen_we, cen_re, acc_we, acc_re;
  logic [CW-1:0]   cen_waddr, cen_raddr, acc_waddr, acc_raddr;
  logic [CEW-1:0]  cen_wdata, cen_rdata, cen_word;
  logic [AWD-1:0]  acc_wdata, acc_rdata, acc_word;
  logic [MaxClusters-1:0] cen_vld_q, cen_vld_d, acc_vld_q, acc_vld_d;
  logic            cen_rv_q, acc_rv_q;

  // Search pipeline
  logic            p1_vld_q, p1_vld_d, p2_vld_q;
  logic [CW-1:0]   p1_idx_q, p1_idx_d, p2_idx_q;
  logic [CEW-1:0]  p2_col_q;
  logic [SQW-1:0]  sq_q [3];
  logic [SQW-1:0]  sq_d [3];
  logic [DW-1:0]   cand_dist;
  logic            first_q, first_d;
  logic [DW-1:0]   best_d_q, best_d_d;
  logic [CW-1:0]   best_q, best_dd;
  logic [CEW-1:0]  bcol_q, bcol_d;

  // End-of-pass division
  logic [AWD-1:0]    eacc_q, eacc_d;
  logic [1:0]        c_q, c_d;
  logic              dstart_q, dstart_d;
  logic              div_done;
  logic [COMP_W-1:0] div_quo;
  logic [SW-1:0]     div_sum;
  logic [COMP_W-1:0] ncol_q [3];
  logic [COMP_W-1:0] ncol_d [3];

  // Result register
  logic             out_vld_q, out_vld_d;
  logic [IDX_W-1:0] out_lbl_q, out_lbl_d;
  logic [PIX_W-1:0] out_r_q, out_r_d, out_g_q, out_g_d, out_b_q, out_b_d;
  logic             out_ovf_q, out_ovf_d;

  // Index helpers
  logic [CW+IDX_W-1:0] hidx_ext, best_ext;
  logic [CW-1:0]       hidx_addr;
  logic                hidx_ok;
  logic [NW-1:0]       acnt;
  int                  kl;

  kcq_ram #(.Width(CEW), .Depth(MaxClusters)) u_cen_ram (
    .clk_i   (clk_i),
    .we_i    (cen_we),
    .waddr_i (cen_waddr),
    .wdata_i (cen_wdata),
    .re_i    (cen_re),
    .raddr_i (cen_raddr),
    .rdata_o (cen_rdata)
  );

  kcq_ram #(.Width(AWD), .Depth(MaxClusters)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  kcq_div #(.SumW(SW), .DenW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart_q),
    .sum_i   (div_sum),
    .den_i   (eacc_q[AWD-1 -: NW]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Clamp k to the stored centroids and take its last index
  always_comb begin
    kl = (k_cfg_i == '0) ? 0 : int'(k_cfg_i) - 1;
    if (kl > MaxClusters - 1) begin
      kl = MaxClusters - 1;
    end
    k_last = CW'(kl);
  end

  assign hidx_ext  = {{CW{1'b0}}, head_i.item.idx};
  assign hidx_addr = hidx_ext[CW-1:0];
  assign hidx_ok   = int'(head_i.item.idx) < MaxClusters;
  assign best_ext  = {{IDX_W{1'b0}}, best_q};

  // Unwritten entries read as zero
  assign cen_word = cen_rv_q ? cen_rdata : '0;
  assign acc_word = acc_rv_q ? acc_rdata : '0;
  assign acnt     = acc_word[AWD-1 -: NW];
  assign div_sum  = eacc_q[c_q*SW +: SW];

  // Squared distance, one centroid a cycle
  always_comb begin
    logic [COMP_W-1:0] a, b, df;
    for (int c = 0; c < 3; c++) begin
      unique case (c)
        0:       a = {item_q.red,   {FRAC_W{1'b0}}};
        1:       a = {item_q.green, {FRAC_W{1'b0}}};
        default: a = {item_q.blue,  {FRAC_W{1'b0}}};
      endcase
      b = cen_word[c*COMP_W +: COMP_W];
      df = (a > b) ? a - b : b - a;
      sq_d[c] = df * df;
    end
  end

  assign cand_dist = DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    j_d       = j_q;
    ovf_d     = ovf_q;
    cen_vld_d = cen_vld_q;
    acc_vld_d = acc_vld_q;
    p1_vld_d  = 1'b0;
    p1_idx_d  = j_q;
    first_d   = first_q;
    best_d_d  = best_d_q;
    best_dd   = best_q;
    bcol_d    = bcol_q;
    eacc_d    = eacc_q;
    c_d       = c_q;
    dstart_d  = 1'b0;
    ncol_d    = ncol_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_lbl_d = out_lbl_q;
    out_r_d   = out_r_q;
    out_g_d   = out_g_q;
    out_b_d   = out_b_q;
    out_ovf_d = out_ovf_q;
    pop_o     = 1'b0;
    cen_we    = 1'b0;
    cen_waddr = hidx_addr;
    cen_wdata = {head_i.item.blue, {FRAC_W{1'b0}}, head_i.item.green, {FRAC_W{1'b0}},
                 head_i.item.red, {FRAC_W{1'b0}}};
    cen_re    = 1'b0;
    cen_raddr = hidx_addr;
    acc_we    = 1'b0;
    acc_waddr = best_q;
    acc_wdata = {acnt + 1'b1,
                 acc_word[2*SW +: SW] + SW'(item_q.blue),
                 acc_word[SW +: SW] + SW'(item_q.green),
                 acc_word[0 +: SW] + SW'(item_q.red)};
    acc_re    = 1'b0;
    acc_raddr = best_q;

    // Keep the best candidate of the search
    if (p2_vld_q && (first_q || cand_dist < best_d_q)) begin
      first_d  = 1'b0;
      best_d_d = cand_dist;
      best_dd  = p2_idx_q;
      bcol_d   = p2_col_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid && !out_vld_q) begin
          pop_o  = 1'b1;
          item_d = head_i.item;
          unique case (head_i.item.cmd)
            CMD_LOAD: begin
              cen_we    = hidx_ok;
              if (hidx_ok) begin
                cen_vld_d[hidx_addr] = 1'b1;
              end
              out_vld_d = 1'b1;
              out_lbl_d = head_i.item.idx;
              out_r_d   = hidx_ok ? head_i.item.red   : '0;
              out_g_d   = hidx_ok ? head_i.item.green : '0;
              out_b_d   = hidx_ok ? head_i.item.blue  : '0;
              out_ovf_d = ovf_q;
            end
            CMD_LOOKUP: begin
              if (hidx_ok) begin
                cen_re  = 1'b1;
                state_d = S_LKRD;
              end else begin
                out_vld_d = 1'b1;
                out_lbl_d = head_i.item.idx;
                out_r_d   = '0;
                out_g_d   = '0;
                out_b_d   = '0;
                out_ovf_d = ovf_q;
              end
            end
            CMD_CLASSIFY: begin
              j_d     = '0;
              first_d = 1'b1;
              state_d = S_SCAN;
            end
            CMD_END: begin
              j_d     = '0;
              state_d = S_ERD;
            end
            default: ;
          endcase
        end
      end

      S_LKRD: begin
        out_vld_d = 1'b1;
        out_lbl_d = item_q.idx;
        out_r_d   = cen_word[0*COMP_W+FRAC_W +: PIX_W];
        out_g_d   = cen_word[1*COMP_W+FRAC_W +: PIX_W];
        out_b_d   = cen_word[2*COMP_W+FRAC_W +: PIX_W];
        out_ovf_d = ovf_q;
        state_d   = S_IDLE;
      end

      // Issue one centroid read a cycle
      S_SCAN: begin
        cen_re    = 1'b1;
        cen_raddr = j_q;
        p1_vld_d  = 1'b1;
        if (j_q == k_last) begin
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      S_DRAIN: begin
        if (!p1_vld_q && !p2_vld_q) begin
          acc_re  = 1'b1;
          state_d = S_ARD;
        end
      end

      S_ARD: begin
        state_d = S_AUPD;
      end

      // Add the pixel unless the count is full
      S_AUPD: begin
        out_vld_d = 1'b1;
        out_lbl_d = best_ext[IDX_W-1:0];
        out_r_d   = bcol_q[0*COMP_W+FRAC_W +: PIX_W];
        out_g_d   = bcol_q[1*COMP_W+FRAC_W +: PIX_W];
        out_b_d   = bcol_q[2*COMP_W+FRAC_W +: PIX_W];
        if (acnt[NW-1]) begin
          ovf_d     = 1'b1;
          out_ovf_d = 1'b1;
        end else begin
          acc_we            = 1'b1;
          acc_vld_d[best_q] = 1'b1;
          out_ovf_d         = ovf_q;
        end
        state_d = S_IDLE;
      end

      S_ERD: begin
        acc_re    = 1'b1;
        acc_raddr = j_q;
        state_d   = S_EWAIT;
      end

      S_EWAIT: begin
        eacc_d = acc_word;
        if (acnt != '0) begin
          c_d      = 2'd0;
          dstart_d = 1'b1;
          state_d  = S_EDIV;
        end else if (j_q == k_last) begin
          acc_vld_d = '0;
          ovf_d     = 1'b0;
          out_vld_d = 1'b1;
          out_lbl_d = item_q.idx;
          out_r_d   = '0;
          out_g_d   = '0;
          out_b_d   = '0;
          out_ovf_d = ovf_q;
          state_d   = S_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_ERD;
        end
      end

      // One component at a time through the divider
      S_EDIV: begin
        if (div_done) begin
          ncol_d[c_q] = div_quo;
          if (c_q == 2'd2) begin
            state_d = S_EWR;
          end else begin
            c_d      = c_q + 1'b1;
            dstart_d = 1'b1;
          end
        end
      end

      S_EWR: begin
        cen_we         = 1'b1;
        cen_waddr      = j_q;
        cen_wdata      = {ncol_q[2], ncol_q[1], ncol_q[0]};
        cen_vld_d[j_q] = 1'b1;
        if (j_q == k_last) begin
          acc_vld_d = '0;
          ovf_d     = 1'b0;
          out_vld_d = 1'b1;
          out_lbl_d = item_q.idx;
          out_r_d   = '0;
          out_g_d   = '0;
          out_b_d   = '0;
          out_ovf_d = ovf_q;
          state_d   = S_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_ERD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ovf_q     <= 1'b0;
      cen_vld_q <= '0;
      acc_vld_q <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      dstart_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ovf_q     <= ovf_d;
      cen_vld_q <= cen_vld_d;
      acc_vld_q <= acc_vld_d;
      p1_vld_q  <= p1_vld_d;
      p2_vld_q  <= p1_vld_q;
      dstart_q  <= dstart_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    j_q       <= j_d;
    first_q   <= first_d;
    best_d_q  <= best_d_d;
    best_q    <= best_dd;
    bcol_q    <= bcol_d;
    eacc_q    <= eacc_d;
    c_q       <= c_d;
    ncol_q    <= ncol_d;
    p1_idx_q  <= p1_idx_d;
    p2_idx_q  <= p1_idx_q;
    p2_col_q  <= cen_word;
    sq_q      <= sq_d;
    out_lbl_q <= out_lbl_d;
    out_r_q   <= out_r_d;
    out_g_q   <= out_g_d;
    out_b_q   <= out_b_d;
    out_ovf_q <= out_ovf_d;
    if (cen_re) begin
      cen_rv_q <= cen_vld_q[cen_raddr];
    end
    if (acc_re) begin
      acc_rv_q <= acc_vld_q[acc_raddr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_ovf_q, out_b_q, out_g_q, out_r_q, out_lbl_q};

  // Checks
  a_pop_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !out_vld_q)
    else $error("command taken while a result is pending");

  a_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_EDIV))
    else $error("divider finished outside the division step");

  a_res_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) != S_SCAN) && ($past(state_q) != S_DRAIN))
    else $error("result raised during the centroid search");

endmodule

### design/kmeans_color_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_color_quantizer
// One k-means pass over streamed RGB pixels: load, classify, end pass, lookup.
// ----------------------------------------------------------------------------
// Each command gives exactly one result transaction. Commands queue in a
// two-entry buffer and execute one at a time. Load answers directly; lookup
// reads the centroid RAM first. Classify reads the centroid RAM one entry a
// cycle into a shared distance unit, then reads and updates the winning
// cluster's accumulators. End pass walks clusters 0 to k-1, with k clamped
// to 1..MAX_CLUSTERS; a non-empty one goes through a bit-serial divider
// one component at a time, an empty one skips it. Centroids are unsigned
// 8.8; results carry the integer part. Write clusters_in_use only while the
// block is idle; a write is taken every cycle.
// ----------------------------------------------------------------------------
module kmeans_color_quantizer #(
  parameter int MAX_CLUSTERS     = 16,
  parameter int PIXEL_COUNT_BITS = 22
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // tdata: cluster_index[3:0], red_in[11:4], green_in[19:12], blue_in[27:20]
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,
  // tuser: command[1:0]
  input  logic [1:0]                s_axis_tuser,
  // tdata: label[3:0], red_out[11:4], green_out[19:12], blue_out[27:20],
  //        count_overflow[28]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kcq_pkg::CFG_W-1:0] cfg_data_i
);
  import kcq_pkg::*;

  logic [CFG_W-1:0] k_cfg_q;
  qhead_t           head;
  logic             pop;

  // Cluster count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q <= CFG_W'(CFG_RESET);
    end else if (cfg_valid_i) begin
      k_cfg_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  kcq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head_o        (head),
    .pop_i         (pop)
  );

  kcq_back #(
    .MaxClusters    (MAX_CLUSTERS),
    .PixelCountBits (PIXEL_COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .k_cfg_i       (k_cfg_q),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### tb/tb_kmeans_color_quantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmeans_color_quantizer
// Streams load, classify, end-pass and lookup commands into the quantizer,
// predicts every answer with a cycle-free model of the centroid file and the
// per-cluster accumulators, and checks each result transaction in order.
// ----------------------------------------------------------------------------
module tb_kmeans_color_quantizer;
  import kcq_pkg::*;

  localparam int NCLUST = 16;
  localparam int CNT_BITS = 22;

  typedef struct packed {
    logic [3:0] label;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       ovf;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  kmeans_color_quantizer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Predictor state
  logic [CFG_W-1:0] k_reg;
  logic [15:0] cent_r [NCLUST];
  logic [15:0] cent_g [NCLUST];
  logic [15:0] cent_b [NCLUST];
  logic [29:0] sum_r [NCLUST];
  logic [29:0] sum_g [NCLUST];
  logic [29:0] sum_b [NCLUST];
  logic [22:0] members [NCLUST];
  logic        ovf_flag;

  item_t   pending_cmds[$];
  answer_t expected_answers[$];
  int      errors;
  bit      hold_sink;
  int      hold_cycles;
  bit      in_taken;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("kmeans_color_quantizer verification failed");
    $finish;
  end

  function automatic int active_k();
    int k;
    k = k_reg;
    if (k == 0) k = 1;
    if (k > NCLUST) k = NCLUST;
    return k;
  endfunction

  function automatic longint unsigned sq(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Work out the answer of one accepted command and advance the state
  function automatic answer_t quantize_cmd(item_t it);
    answer_t a;
    int best;
    longint unsigned best_d, d;
    a = '0;
    a.label = it.idx;
    case (it.cmd)
      CMD_LOAD, CMD_LOOKUP: begin
        if (it.cmd == CMD_LOAD) begin
          cent_r[it.idx] = {it.red, 8'h00};
          cent_g[it.idx] = {it.green, 8'h00};
          cent_b[it.idx] = {it.blue, 8'h00};
        end
        a.red = cent_r[it.idx][15:8];
        a.green = cent_g[it.idx][15:8];
        a.blue = cent_b[it.idx][15:8];
        a.ovf = ovf_flag;
      end
      CMD_CLASSIFY: begin
        best = 0;
        best_d = 0;
        for (int j = 0; j < active_k(); j++) begin
          d = sq({it.red, 8'h00}, cent_r[j]) + sq({it.green, 8'h00}, cent_g[j])
              + sq({it.blue, 8'h00}, cent_b[j]);
          if (j == 0 || d < best_d) begin
            best_d = d;
            best = j;
          end
        end
        a.label = 4'(best);
        a.red = cent_r[best][15:8];
        a.green = cent_g[best][15:8];
        a.blue = cent_b[best][15:8];
        if (members[best] >= (23'd1 << CNT_BITS)) ovf_flag = 1'b1;
        else begin
          sum_r[best] += it.red;
          sum_g[best] += it.green;
          sum_b[best] += it.blue;
          members[best] += 1;
        end
        a.ovf = ovf_flag;
      end
      default: begin
        for (int j = 0; j < active_k(); j++)
          if (members[j] != 0) begin
            cent_r[j] = 16'(({8'h00, sum_r[j]} << 8) / members[j]);
            cent_g[j] = 16'(({8'h00, sum_g[j]} << 8) / members[j]);
            cent_b[j] = 16'(({8'h00, sum_b[j]} << 8) / members[j]);
          end
        for (int j = 0; j < NCLUST; j++) begin
          sum_r[j] = '0; sum_g[j] = '0; sum_b[j] = '0; members[j] = '0;
        end
        a.ovf = ovf_flag;
        ovf_flag = 1'b0;
      end
    endcase
    return a;
  endfunction

  function automatic item_t make_cmd(cmd_e c, int idx, int r, int g, int b);
    item_t it;
    it.cmd = c; it.idx = 4'(idx); it.red = 8'(r); it.green = 8'(g); it.blue = 8'(b);
    return it;
  endfunction

  function automatic item_t rand_pixel();
    return make_cmd(CMD_CLASSIFY, $urandom_range(0, 15), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Driver: present queued commands with random gaps
  int send_gap;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_taken) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_cmds.size() > 0) begin
        item_t it;
        it = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.cmd;
        s_axis_tdata <= {4'h0, it.blue, it.green, it.red, it.idx};
        send_gap <= $urandom_range(0, 9);
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // Predict on acceptance
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_answers.push_back(quantize_cmd(make_cmd(cmd_e'(s_axis_tuser),
          s_axis_tdata[3:0], s_axis_tdata[11:4], s_axis_tdata[19:12],
          s_axis_tdata[27:20])));
  end

  // Receiver back-pressure, with an optional long hold-off
  int sink_gap;
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (hold_sink) begin
      m_axis_tready <= 1'b0;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      else hold_sink <= 1'b0;
    end else if (sink_gap > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sink_gap <= $urandom_range(0, 9);
      if (expected_answers.size() == 0) begin
        $error("result with no expectation: %h", m_axis_tdata);
        errors++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (m_axis_tdata[3:0] !== e.label) begin
          $error("label exp %0d got %0d", e.label, m_axis_tdata[3:0]); errors++;
        end
        if (m_axis_tdata[11:4] !== e.red) begin
          $error("red_out exp %0d got %0d", e.red, m_axis_tdata[11:4]); errors++;
        end
        if (m_axis_tdata[19:12] !== e.green) begin
          $error("green_out exp %0d got %0d", e.green, m_axis_tdata[19:12]); errors++;
        end
        if (m_axis_tdata[27:20] !== e.blue) begin
          $error("blue_out exp %0d got %0d", e.blue, m_axis_tdata[27:20]); errors++;
        end
        if (m_axis_tdata[28] !== e.ovf) begin
          $error("count_overflow exp %0d got %0d", e.ovf, m_axis_tdata[28]); errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_k(int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    k_reg = CFG_W'(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // A pass: seed k centroids, classify pixels with odd random commands mixed in, end, look up all 16
  task automatic queue_pass(int k, int pixels);
    for (int j = 0; j < k; j++)
      pending_cmds.push_back(make_cmd(CMD_LOAD, j, $urandom_range(0, 255),
                                      $urandom_range(0, 255), $urandom_range(0, 255)));
    for (int p = 0; p < pixels; p++)
      if ($urandom_range(0, 19) == 0)
        pending_cmds.push_back(make_cmd(cmd_e'($urandom_range(0, 3)),
            $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 255)));
      else pending_cmds.push_back(rand_pixel());
    pending_cmds.push_back(make_cmd(CMD_END, $urandom_range(0, 15), 0, 0, 0));
    for (int j = 0; j < 16; j++)
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, j, 0, 0, 0));
  endtask

  initial begin
    int kset[6];
    kset = '{16, 1, 0, 5, 31, 3};
    errors = 0;
    hold_sink = 0;
    hold_cycles = 0;
    send_gap = 0;
    sink_gap = 0;
    k_reg = CFG_W'(CFG_RESET);
    ovf_flag = 0;
    for (int j = 0; j < NCLUST; j++) begin
      cent_r[j] = 0; cent_g[j] = 0; cent_b[j] = 0;
      sum_r[j] = 0; sum_g[j] = 0; sum_b[j] = 0; members[j] = 0;
    end
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_LOAD;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset centroids, extremes, ties, every command, empty clusters
    pending_cmds.push_back(make_cmd(CMD_CLASSIFY, 9, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 15, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 0, 255, 255, 255));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 15, 255, 0, 170));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 3, 85, 85, 85));
    pending_cmds.push_back(make_cmd(CMD_LOAD, 4, 85, 85, 85));
    pending_cmds.push_back(make_cmd(CMD_CLASSIFY, 0, 85, 85, 85));
    pending_cmds.push_back(make_cmd(CMD_CLASSIFY, 15, 255, 255, 255));
    pending_cmds.push_back(make_cmd(CMD_CLASSIFY, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_CLASSIFY, 0, 254, 1, 128));
    pending_cmds.push_back(make_cmd(CMD_END, 15, 255, 255, 255));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 3, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 15, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_END, 0, 0, 0, 0));
    drain();

    // Random passes at several k settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      write_k(kset[ph]);
      queue_pass(active_k(), 230);
      if (ph == 1) begin
        // stall the receiver for a long stretch while commands keep arriving
        @(negedge clk_i);
        hold_cycles = 400;
        hold_sink = 1'b1;
      end
      if (ph == 3) begin
        // sender pauses until every expected result has come
        while (pending_cmds.size() > 100) @(posedge clk_i);
        begin
          item_t saved[$];
          saved = pending_cmds;
          pending_cmds.delete();
          while (s_axis_tvalid || expected_answers.size() > 0) @(posedge clk_i);
          pending_cmds = saved;
        end
      end
      drain();
    end

    if (errors == 0) $display("kmeans_color_quantizer verification clean");
    else $display("kmeans_color_quantizer verification failed");
    $finish;
  end

endmodule

### sim.f
design/kcq_pkg.sv
design/kcq_ram.sv
design/kcq_div.sv
design/kcq_front.sv
design/kcq_back.sv
design/kmeans_color_quantizer.sv
tb/tb_kmeans_color_quantizer.sv
